### rtl/overlapping_frame_splitter_assert.svh
// Assertion macros used by the overlapping frame splitter RTL.
`ifndef OVERLAPPING_FRAME_SPLITTER_ASSERT_SVH
`define OVERLAPPING_FRAME_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define OFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("overlapping_frame_splitter assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define OFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("overlapping_frame_splitter assertion failed");
`else
`define OFS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OFS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/ofs_pkg.sv
// Types and constants of the overlapping frame splitter.
package ofs_pkg;

    localparam int CFG_W     = 7;
    localparam int SMP_W     = 24;
    localparam int FNUM_W    = 16;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int AW        = 6;

    localparam logic [CFG_W-1:0] MAX_FRAME = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_SIZE   = 2'd1;

    localparam logic OP_SAMPLE = 1'b0;

    localparam logic [STAT_W-1:0] ST_FRAME = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ERR   = 2'd2;

    typedef struct packed {
        logic                    opcode;
        logic signed [SMP_W-1:0] sample_in;
    } t_in_word;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic                    last_of_frame;
        logic [FNUM_W-1:0]       frame_number;
        logic [STAT_W-1:0]       status;
        logic                    more_pending;
    } t_out_word;

    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [AW-1:0] rd_addr;
    } t_ring_ctl;

endpackage

### rtl/ofs_ring.sv
// Sample ring: one write port and one registered read port.
module ofs_ring
    import ofs_pkg::*;
(
    input  logic                    i_clk,
    input  t_ring_ctl               i_ctl,
    input  logic signed [SMP_W-1:0] i_wr_data,
    output logic signed [SMP_W-1:0] o_rd_data
);

    logic signed [SMP_W-1:0] r_mem [2**AW];
    logic signed [SMP_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_ctl.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/overlapping_frame_splitter.sv
// Top level of the overlapping frame splitter: sequencer, registers and output word.
//
// Usage. Input words (opcode, sample_in) arrive on i_in_valid/o_in_ready; a sample
// word stores one sample in a 64-entry ring, a flush word ends the stream. Result
// words leave on o_out_valid/i_out_ready through one output register. Register
// writes (index 0 frame_size, index 1 hop_size) use i_cfg_valid/o_cfg_ready, are
// always taken, and restart the stream; write them only while the block is idle.
// Sequence. A sample that does not complete a frame leaves the block idle. A sample
// that completes a frame, or a flush that has samples pending, starts a frame: the
// block passes through a prepare state into the emit state, which loads the first
// word into the output register, and then one word per cycle follows while the
// receiver is ready. The single read port of the ring sets that pace: one frame
// sample is fetched per cycle through one shared address adder.
// A flush with nothing pending, or under an invalid configuration, gives a single
// status word. The input is not ready while a frame or status word is sequenced.
// When the receiver stalls, the output word and the ring read address hold and
// the sequence resumes without loss. Reset clears the pointers, counters and
// output valid and loads frame_size 64 and hop_size 32; the ring is not cleared.
`include "overlapping_frame_splitter_assert.svh"
module overlapping_frame_splitter
    import ofs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_STAT = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CFG_W-1:0]  r_fs, n_fs;
    logic [CFG_W-1:0]  r_hs, n_hs;
    logic [AW-1:0]     r_wp, n_wp;
    logic [CFG_W-1:0]  r_cnt, n_cnt;
    logic [FNUM_W-1:0] r_fc, n_fc;
    logic              r_out_valid, n_out_valid;

    logic [AW-1:0]     r_base, n_base;
    logic [CFG_W-1:0]  r_held, n_held;
    logic [CFG_W-1:0]  r_k, n_k;
    logic              r_more, n_more;
    logic [STAT_W-1:0] r_stat, n_stat;
    t_out_word         r_out, n_out;

    logic                    w_cfg_ok;
    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_adv;
    logic [CFG_W-1:0]        w_cnt_inc;
    logic [CFG_W-1:0]        w_k_next;
    logic [CFG_W-1:0]        w_rd_k;
    t_ring_ctl               w_ring_ctl;
    logic signed [SMP_W-1:0] w_rd_data;
    logic                    w_stat_shown;
    logic                    w_stat_blank;
    logic                    w_frame_due;

    assign w_cfg_ok = (r_fs != '0) && (r_fs <= MAX_FRAME) &&
                      (r_hs != '0) && (r_hs <= r_fs);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_adv       = (r_state == S_EMIT) && w_out_free;
    assign w_cnt_inc   = r_cnt + 7'd1;
    assign w_k_next    = r_k + 7'd1;

    // The read address moves on only when a word goes into the output register,
    // so a stall leaves the fetched sample in place.
    assign w_rd_k             = w_adv ? w_k_next : r_k;
    assign w_ring_ctl.rd_addr = r_base + w_rd_k[AW-1:0];
    assign w_ring_ctl.wr_addr = r_wp;
    assign w_ring_ctl.wr_en   = w_in_acc && (i_in_word.opcode == OP_SAMPLE) && w_cfg_ok;

    ofs_ring u_ring (
        .i_clk     (i_clk),
        .i_ctl     (w_ring_ctl),
        .i_wr_data (i_in_word.sample_in),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_fs        = r_fs;
        n_hs        = r_hs;
        n_wp        = r_wp;
        n_cnt       = r_cnt;
        n_fc        = r_fc;
        n_base      = r_base;
        n_held      = r_held;
        n_k         = r_k;
        n_more      = r_more;
        n_stat      = r_stat;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_word.opcode == OP_SAMPLE) begin
                        // Under an invalid configuration the sample is dropped.
                        if (w_cfg_ok) begin
                            n_wp = r_wp + 6'd1;
                            if (w_cnt_inc >= r_fs) begin
                                n_held  = r_fs;
                                n_base  = r_wp + 6'd1 - r_fs[AW-1:0];
                                n_more  = 1'b0;
                                n_cnt   = r_fs - r_hs;
                                n_k     = '0;
                                n_state = S_PREP;
                            end else begin
                                n_cnt = w_cnt_inc;
                            end
                        end
                    end else if (!w_cfg_ok) begin
                        n_stat  = ST_ERR;
                        n_cnt   = '0;
                        n_fc    = '0;
                        n_state = S_STAT;
                    end else if (r_cnt == '0) begin
                        n_stat  = ST_DONE;
                        n_cnt   = '0;
                        n_fc    = '0;
                        n_state = S_STAT;
                    end else begin
                        // Flush the oldest pending frame; what lies past one hop
                        // stays pending for the next flush.
                        n_held  = r_cnt;
                        n_base  = r_wp - r_cnt[AW-1:0];
                        n_more  = (r_cnt > r_hs);
                        n_cnt   = (r_cnt > r_hs) ? (r_cnt - r_hs) : '0;
                        n_k     = '0;
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out.sample_out    = (r_k < r_held) ? w_rd_data : '0;
                    n_out.last_of_frame = (w_k_next == r_fs);
                    n_out.frame_number  = r_fc;
                    n_out.status        = ST_FRAME;
                    n_out.more_pending  = r_more;
                    n_out_valid         = 1'b1;
                    n_k                 = w_k_next;
                    if (w_k_next == r_fs) begin
                        n_fc    = r_fc + 16'd1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_STAT: begin
                if (w_out_free) begin
                    n_out.sample_out    = '0;
                    n_out.last_of_frame = 1'b0;
                    n_out.frame_number  = '0;
                    n_out.status        = r_stat;
                    n_out.more_pending  = 1'b0;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A register write restarts the stream but keeps the ring and pointer.
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_FRAME_SIZE) begin
                n_fs  = i_cfg_data;
                n_cnt = '0;
                n_fc  = '0;
            end else if (i_cfg_index == CFG_HOP_SIZE) begin
                n_hs  = i_cfg_data;
                n_cnt = '0;
                n_fc  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fs        <= MAX_FRAME;
            r_hs        <= 7'd32;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_fc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fs        <= n_fs;
            r_hs        <= n_hs;
            r_wp        <= n_wp;
            r_cnt       <= n_cnt;
            r_fc        <= n_fc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_held <= n_held;
        r_k    <= n_k;
        r_more <= n_more;
        r_stat <= n_stat;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Terms of the checks below.
    assign w_stat_shown = r_out_valid && (r_out.status != ST_FRAME);
    assign w_stat_blank = (r_out.sample_out == '0) && !r_out.last_of_frame &&
                          (r_out.frame_number == '0);
    assign w_frame_due  = w_in_acc && (i_in_word.opcode == OP_SAMPLE) && w_cfg_ok &&
                          (w_cnt_inc >= r_fs) && !i_cfg_valid;

    // The frame index never runs past the frame while words are sequenced.
    `OFS_ASSERT_IMP(a_k_in_frame, i_clk, i_rst_n, r_state == S_EMIT, r_k < r_fs)
    // The pending count never exceeds one frame.
    `OFS_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, w_cfg_ok, r_cnt <= r_fs)
    // Done and error words carry no sample, mark and frame number.
    `OFS_ASSERT_IMP(a_stat_clean, i_clk, i_rst_n, w_stat_shown, w_stat_blank)
    // A sample that completes a frame starts the frame sequence.
    `OFS_ASSERT_NXT(a_frame_start, i_clk, i_rst_n, w_frame_due, r_state == S_PREP)

endmodule
